// ===== sv/hotplug_detect_debounce_classifier_assert.svh =====
// Assertion macros used by the hot-plug-detect classifier core.
// Each macro expects clk_i and rst_ni in scope.
`ifndef HOTPLUG_DETECT_DEBOUNCE_CLASSIFIER_ASSERT_SVH
`define HOTPLUG_DETECT_DEBOUNCE_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF

// Clocked property, checked only outside reset.
`define HPDDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked property, checked during reset as well.
`define HPDDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define HPDDC_ASSERT(lbl, prop, msg)
`define HPDDC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== sv/hpddc_pkg.sv =====
package hpddc_pkg;

  // Widths of the tick counter and the configuration registers.
  localparam int unsigned TickW = 20;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};
  localparam logic [TickW-1:0] IrqMinReset = TickW'(250);
  localparam logic [TickW-1:0] LevelMinReset = TickW'(2000);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegIrqMin = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLevelMin = 1'b1;

  // What an input beat carries.
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_EDGE = 1'b1
  } hpddc_kind_e;

  // Reported events.
  typedef enum logic [1:0] {
    EVT_LOW  = 2'd0,
    EVT_HIGH = 2'd1,
    EVT_IRQ  = 2'd2
  } hpddc_event_e;

  // One classification result handed from the core to the output stage.
  typedef struct packed {
    logic         valid;
    hpddc_event_e code;
  } hpddc_result_t;

endpackage

// ===== sv/hpddc_core.sv =====
`include "hotplug_detect_debounce_classifier_assert.svh"

module hpddc_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  hpddc_pkg::hpddc_kind_e            kind_i,
  input  logic                              pin_i,
  input  logic [hpddc_pkg::TickW-1:0]       irq_min_i,
  input  logic [hpddc_pkg::TickW-1:0]       level_min_i,
  output hpddc_pkg::hpddc_result_t          result_o
);
  import hpddc_pkg::*;

  logic [TickW-1:0] ticks_q, ticks_d;
  logic [TickW-1:0] countdown_q, countdown_d;
  logic             stored_q, stored_d;
  logic             armed_q, armed_d;

  // Classify the current beat and work out the next state.
  always_comb begin
    ticks_d     = ticks_q;
    countdown_d = countdown_q;
    stored_d    = stored_q;
    armed_d     = armed_q;
    result_o    = '{valid: 1'b0, code: EVT_LOW};
    if (step_i) begin
      unique case (kind_i)
        KIND_TICK: begin
          if (ticks_q != TickMax) begin
            ticks_d = ticks_q + TickW'(1);
          end
          if (armed_q) begin
            if (countdown_q <= TickW'(1)) begin
              armed_d     = 1'b0;
              countdown_d = '0;
              if (pin_i == stored_q) begin
                result_o = '{valid: 1'b1, code: (stored_q ? EVT_HIGH : EVT_LOW)};
              end
            end else begin
              countdown_d = countdown_q - TickW'(1);
            end
          end
        end
        KIND_EDGE: begin
          // The gap is the count before this edge; any settle timer is dropped.
          ticks_d     = '0;
          armed_d     = 1'b0;
          countdown_d = '0;
          if (ticks_q >= irq_min_i) begin
            if (!stored_q && pin_i && (ticks_q < level_min_i)) begin
              result_o = '{valid: 1'b1, code: EVT_IRQ};
            end else if (ticks_q >= level_min_i) begin
              armed_d     = 1'b1;
              countdown_d = level_min_i;
            end
            stored_d = pin_i;
          end
        end
        default: begin
          ticks_d = ticks_q;
        end
      endcase
    end
  end

  // Classifier state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q     <= '0;
      countdown_q <= '0;
      stored_q    <= 1'b0;
      armed_q     <= 1'b0;
    end else begin
      ticks_q     <= ticks_d;
      countdown_q <= countdown_d;
      stored_q    <= stored_d;
      armed_q     <= armed_d;
    end
  end

  `HPDDC_ASSERT(a_edge_clears_count, (step_i && kind_i == KIND_EDGE) |=> (ticks_q == '0), "edge did not restart the tick count")
  `HPDDC_ASSERT(a_irq_on_rising, (result_o.valid && result_o.code == EVT_IRQ) |-> (kind_i == KIND_EDGE && pin_i && !stored_q), "interrupt reported without a rising edge from low")
  `HPDDC_ASSERT(a_level_report, (result_o.valid && result_o.code != EVT_IRQ) |-> (kind_i == KIND_TICK && armed_q && result_o.code[0] == stored_q && pin_i == stored_q), "level report disagrees with the stored level")
  `HPDDC_ASSERT(a_disarm_on_step, $fell(armed_q) |-> $past(step_i), "settle timer disarmed without a beat")
  `HPDDC_ASSERT_ALWAYS(a_result_needs_step, result_o.valid |-> step_i, "result produced without a beat")

endmodule

// ===== sv/hotplug_detect_debounce_classifier.sv =====
// Channel      | Direction | Ports          | Content
// -------------+-----------+----------------+-------------------------------------------
// s_axis       | in        | tvalid/tready  | tuser: kind, tdata: pin_level
// m_axis       | out       | tvalid/tready  | tdata: event_code
// cfg          | in        | we/idx/wdata   | 0: irq_min_ticks, 1: level_min_ticks
//
// Each beat is captured in an input register and classified once it may advance,
// with any result landing in the output register.
// One beat per cycle is sustained while the output side takes results.
// When the output register is held by a stalled result, the input register holds
// its beat and s_axis_tready falls only once both are occupied.
// Reset clears the valid flags and classifier state and loads the registers with 250 and 2000 ticks.
module hotplug_detect_debounce_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [0] pin_level, [7:1] zero
  input  logic                                s_axis_tuser,  // [0] kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // [1:0] event_code, [7:2] zero
  input  logic                                cfg_we_i,
  input  logic [hpddc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [hpddc_pkg::TickW-1:0]         cfg_wdata_i
);
  import hpddc_pkg::*;

  logic [TickW-1:0] irq_min_q;
  logic [TickW-1:0] level_min_q;

  logic             in_valid_q;
  hpddc_kind_e      in_kind_q;
  logic             in_pin_q;

  logic             out_valid_q, out_valid_d;
  hpddc_event_e     out_code_q, out_code_d;

  logic             advance;
  hpddc_result_t    result;

  // The held beat moves on once the output register is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_min_q   <= IrqMinReset;
      level_min_q <= LevelMinReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegIrqMin:   irq_min_q   <= cfg_wdata_i;
        RegLevelMin: level_min_q <= cfg_wdata_i;
        default:     irq_min_q   <= irq_min_q;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q <= hpddc_kind_e'(s_axis_tuser);
      in_pin_q  <= s_axis_tdata[0];
    end
  end

  hpddc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .kind_i      (in_kind_q),
    .pin_i       (in_pin_q),
    .irq_min_i   (irq_min_q),
    .level_min_i (level_min_q),
    .result_o    (result)
  );

  // Output register: loads a result, or empties once its beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance && result.valid) begin
      out_valid_d = 1'b1;
      out_code_d  = result.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_code_q <= out_code_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_code_q};

endmodule
